/* sv/pcbs_pkg.sv */
// Constants, types and codes shared by the periodic cubic B-spline sampler.
`default_nettype none
package pcbs_pkg;

  localparam int MAX_CTRL = 16;
  localparam int CTRL_W   = $clog2(MAX_CTRL);
  localparam int FRAC_W   = 16;
  localparam int VAL_W    = 24;
  localparam int TICK_W   = 10;
  localparam int NCTL_W   = 5;
  localparam int PER_W    = 10;

  // pipeline geometry
  localparam int MOD_N  = TICK_W;             // tick mod period, one quotient bit per stage
  localparam int QUO_W  = CTRL_W + FRAC_W;    // segment and fraction
  localparam int DIV_N  = QUO_W;              // one quotient bit per stage
  localparam int PROD_W = TICK_W + NCTL_W;
  localparam int W_W    = FRAC_W + 6;         // signed basis weight
  localparam int ACC_W  = W_W + VAL_W + 2;
  localparam int MAG_W  = ACC_W - FRAC_W;
  localparam int RCP_W  = 32;
  localparam int RCP_SH = 34;                 // x * ceil(2^33 / 3) >> 34 == x / 6
  localparam int Q_W    = MAG_W + RCP_W - RCP_SH;

  localparam logic [RCP_W-1:0] RECIP_3 = 32'hAAAA_AAAB;
  localparam logic [VAL_W-1:0] ANGLE_LIMIT = VAL_W'(90 << FRAC_W);
  localparam logic signed [W_W-1:0] W_ONE = W_W'(1 << FRAC_W);

  // stream packing
  localparam int IN_DATA_W  = ((CTRL_W + VAL_W + TICK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;
  localparam int IDX_LSB    = 0;
  localparam int VAL_LSB    = IDX_LSB + CTRL_W;
  localparam int TICK_LSB   = VAL_LSB + VAL_W;

  // configuration
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = PER_W;
  localparam logic [CFG_IDX_W-1:0] CFG_NCTL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PER  = 1'd1;
  localparam logic [NCTL_W-1:0] NCTL_RST = NCTL_W'(8);
  localparam logic [PER_W-1:0]  PER_RST  = PER_W'(240);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic                    vld;
    logic                    mode;
    logic [CTRL_W-1:0]       idx;
    logic signed [VAL_W-1:0] val;
  } item_t;

  typedef struct packed {
    item_t             it;
    logic [TICK_W-1:0] rem;
  } mod_st_t;

  typedef struct packed {
    item_t            it;
    logic [PER_W-1:0] rem;
    logic [QUO_W-1:0] qd;
  } div_st_t;

endpackage
`default_nettype wire

/* sv/periodic_cubic_bspline_sampler.sv */
// Periodic uniform cubic B-spline sampler: control point store and sample pipeline.
//
// Usage:
//   Config port: write num_controls (index 0) and period (index 1) while idle.
//   Input stream: tuser = mode. A load beat (mode 0) writes point_value into
//   slot point_index and yields no output beat. A sample beat (mode 1) yields
//   one output beat: the curve value at tick_index, clamped to +/-90, with
//   was_clamped in tuser.
//   Pipeline: an input beat passes 10 stages of tick mod period, one multiply
//   stage, 20 stages of a restoring divider, 8 stages of store read and
//   weighting, then the output register. Throughput: one beat per cycle while
//   the skid register is empty, set by the fully pipelined dividers and the two
//   dual-read point stores read in a single stage.
//   Loads write the store in the same stage that samples read it, so order is
//   kept with no forwarding.
//   Reset: config returns to 8 controls and a period of 240; the pipeline and
//   output drain. The point store keeps no reset value; load every slot in use
//   before sampling.
//   Stall: a skid register behind the output register takes one more result
//   while the receiver holds; once it fills, the whole pipeline and
//   s_axis_tready hold until the receiver takes a beat.
`default_nettype none
module periodic_cubic_bspline_sampler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pcbs_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // point_index, point_value, tick_index, zero pad
  input  logic [pcbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // angle
  output logic [pcbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // was_clamped
  output logic [0:0]                       m_axis_tuser
);
  import pcbs_pkg::*;

  function automatic mod_st_t mod_step(mod_st_t s, logic [PER_W-1:0] per, int sh);
    logic [TICK_W+PER_W-1:0] d;
    d = (TICK_W + PER_W)'(per) << sh;
    if ((TICK_W + PER_W)'(s.rem) >= d) begin
      s.rem = s.rem - d[TICK_W-1:0];
    end
    return s;
  endfunction

  function automatic div_st_t div_step(div_st_t s, logic [PER_W-1:0] per);
    logic [PER_W:0] r;
    r    = {s.rem, s.qd[QUO_W-1]};
    s.qd = {s.qd[QUO_W-2:0], 1'b0};
    if (r >= {1'b0, per}) begin
      r       = r - {1'b0, per};
      s.qd[0] = 1'b1;
    end
    s.rem = r[PER_W-1:0];
    return s;
  endfunction

  // ---------------------------------------------------------------- config
  logic [NCTL_W-1:0] nctl_q;
  logic [PER_W-1:0]  per_q;
  logic [NCTL_W-1:0] n_eff;
  logic [PER_W-1:0]  per_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nctl_q <= NCTL_RST;
      per_q  <= PER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NCTL: nctl_q <= cfg_wdata_i[NCTL_W-1:0];
        CFG_PER:  per_q  <= cfg_wdata_i[PER_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    priority if (nctl_q == '0) begin
      n_eff = NCTL_W'(1);
    end else if (nctl_q > NCTL_W'(MAX_CTRL)) begin
      n_eff = NCTL_W'(MAX_CTRL);
    end else begin
      n_eff = nctl_q;
    end
    per_eff = (per_q == '0) ? PER_W'(1) : per_q;
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic skid_vld_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  item_t   in_it;
  mod_st_t md_in [MOD_N];
  mod_st_t md_q  [MOD_N];
  div_st_t mul_q;
  div_st_t dv_in [DIV_N];
  div_st_t dv_q  [DIV_N];
  logic [PROD_W-1:0] prod;

  always_comb begin
    in_it.vld  = s_axis_tvalid;
    in_it.mode = s_axis_tuser[0];
    in_it.idx  = s_axis_tdata[IDX_LSB +: CTRL_W];
    in_it.val  = $signed(s_axis_tdata[VAL_LSB +: VAL_W]);
    md_in[0].it  = in_it;
    md_in[0].rem = s_axis_tdata[TICK_LSB +: TICK_W];
    for (int k = 1; k < MOD_N; k++) begin
      md_in[k] = md_q[k-1];
    end
    prod     = md_q[MOD_N-1].rem * n_eff;
    dv_in[0] = mul_q;
    for (int k = 1; k < DIV_N; k++) begin
      dv_in[k] = dv_q[k-1];
    end
  end

  // tick mod period, multiply by count, then (tw * n << FRAC) / period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MOD_N; k++) begin
        md_q[k] <= '0;
      end
      mul_q <= '0;
      for (int k = 0; k < DIV_N; k++) begin
        dv_q[k] <= '0;
      end
    end else if (en) begin
      for (int k = 0; k < MOD_N; k++) begin
        md_q[k] <= mod_step(md_in[k], per_eff, MOD_N - 1 - k);
      end
      mul_q.it  <= md_q[MOD_N-1].it;
      mul_q.rem <= PER_W'(prod >> CTRL_W);
      mul_q.qd  <= {prod[CTRL_W-1:0], {FRAC_W{1'b0}}};
      for (int k = 0; k < DIV_N; k++) begin
        dv_q[k] <= div_step(dv_in[k], per_eff);
      end
    end
  end

  // ---------------------------------------------------------------- store
  item_t             dv_it;
  logic [CTRL_W-1:0] seg;
  logic [FRAC_W-1:0] frac;
  logic [CTRL_W-1:0] rd_idx [4];
  logic              st_wr;

  always_comb begin
    dv_it     = dv_q[DIV_N-1].it;
    seg       = dv_q[DIV_N-1].qd[QUO_W-1 -: CTRL_W];
    frac      = dv_q[DIV_N-1].qd[FRAC_W-1:0];
    rd_idx[0] = (seg == '0) ? CTRL_W'(n_eff - NCTL_W'(1)) : seg - CTRL_W'(1);
    rd_idx[1] = seg;
    rd_idx[2] = (NCTL_W'(seg) + NCTL_W'(1) == n_eff) ? '0 : seg + CTRL_W'(1);
    rd_idx[3] = (NCTL_W'(rd_idx[2]) + NCTL_W'(1) == n_eff) ? '0 : rd_idx[2] + CTRL_W'(1);
    st_wr     = en && dv_it.vld && (dv_it.mode == MODE_LOAD);
  end

  logic signed [VAL_W-1:0] mem_a [MAX_CTRL];
  logic signed [VAL_W-1:0] mem_b [MAX_CTRL];
  logic signed [VAL_W-1:0] rd_q  [4];

  always_ff @(posedge clk_i) begin
    if (st_wr) begin
      mem_a[dv_it.idx] <= dv_it.val;
    end
    if (en) begin
      rd_q[0] <= mem_a[rd_idx[0]];
      rd_q[1] <= mem_a[rd_idx[1]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_wr) begin
      mem_b[dv_it.idx] <= dv_it.val;
    end
    if (en) begin
      rd_q[2] <= mem_b[rd_idx[2]];
      rd_q[3] <= mem_b[rd_idx[3]];
    end
  end

  // ---------------------------------------------------------------- weighting
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, s_vld_q, g_vld_q, h_vld_q;
  logic g_neg_q, h_neg_q;
  logic [FRAC_W-1:0] a_f_q, a_f2_q, b_f_q, b_f2_q, b_f3_q;
  logic [2*FRAC_W-1:0] sq, cu;
  logic signed [VAL_W-1:0] b_p_q [4];
  logic signed [VAL_W-1:0] c_p_q [4];
  logic signed [W_W-1:0]   c_w_q [4];
  logic signed [W_W-1:0]   ef, ef2, ef3, w_d [4];
  logic signed [ACC_W-1:0] pr [4];
  logic signed [ACC_W-1:0] d_pr_q [4];
  logic signed [ACC_W-1:0] e_s01_q, e_s23_q, acc_q, acc_abs;
  logic [MAG_W-1:0]        g_mag_q;
  logic [MAG_W+RCP_W-1:0]  h_prod_q;

  always_comb begin
    sq  = frac * frac;
    cu  = a_f2_q * a_f_q;
    ef  = $signed(W_W'(b_f_q));
    ef2 = $signed(W_W'(b_f2_q));
    ef3 = $signed(W_W'(b_f3_q));
    w_d[0] = W_ONE - ((ef <<< 1) + ef) + ((ef2 <<< 1) + ef2) - ef3;
    w_d[1] = (W_ONE <<< 2) - ((ef2 <<< 2) + (ef2 <<< 1)) + ((ef3 <<< 1) + ef3);
    w_d[2] = W_ONE + ((ef <<< 1) + ef) + ((ef2 <<< 1) + ef2) - ((ef3 <<< 1) + ef3);
    w_d[3] = ef3;
    for (int k = 0; k < 4; k++) begin
      pr[k] = c_w_q[k] * c_p_q[k];
    end
    acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
    end else if (en) begin
      // loads end at the store
      a_vld_q <= dv_it.vld && (dv_it.mode == MODE_SAMPLE);
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      s_vld_q <= e_vld_q;
      g_vld_q <= s_vld_q;
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_f_q    <= frac;
      a_f2_q   <= sq[2*FRAC_W-1:FRAC_W];
      b_f_q    <= a_f_q;
      b_f2_q   <= a_f2_q;
      b_f3_q   <= cu[2*FRAC_W-1:FRAC_W];
      for (int k = 0; k < 4; k++) begin
        b_p_q[k]  <= rd_q[k];
        c_p_q[k]  <= b_p_q[k];
        c_w_q[k]  <= w_d[k];
        d_pr_q[k] <= pr[k];
      end
      e_s01_q  <= d_pr_q[0] + d_pr_q[1];
      e_s23_q  <= d_pr_q[2] + d_pr_q[3];
      acc_q    <= e_s01_q + e_s23_q;
      g_neg_q  <= acc_q[ACC_W-1];
      g_mag_q  <= acc_abs[ACC_W-1:FRAC_W];
      h_neg_q  <= g_neg_q;
      h_prod_q <= g_mag_q * RECIP_3;
    end
  end

  // ---------------------------------------------------------------- clamp and output
  logic [Q_W-1:0]   q_mag;
  logic             res_clamp;
  logic [VAL_W-1:0] res_mag, res_angle;
  logic             push, pop;
  logic             out_vld_q;
  logic [VAL_W-1:0] out_angle_q, skid_angle_q;
  logic             out_clamp_q, skid_clamp_q;

  always_comb begin
    q_mag     = h_prod_q[MAG_W+RCP_W-1:RCP_SH];
    res_clamp = q_mag > Q_W'(ANGLE_LIMIT);
    res_mag   = res_clamp ? ANGLE_LIMIT : q_mag[VAL_W-1:0];
    res_angle = h_neg_q ? -res_mag : res_mag;
    push      = en && h_vld_q;
    pop       = out_vld_q && m_axis_tready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      priority if (skid_vld_q) begin
        if (pop) begin
          skid_vld_q <= 1'b0;
        end
      end else if (push) begin
        if (!out_vld_q || pop) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (skid_vld_q) begin
      if (pop) begin
        out_angle_q <= skid_angle_q;
        out_clamp_q <= skid_clamp_q;
      end
    end else if (push) begin
      if (!out_vld_q || pop) begin
        out_angle_q <= res_angle;
        out_clamp_q <= res_clamp;
      end else begin
        skid_angle_q <= res_angle;
        skid_clamp_q <= res_clamp;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_angle_q);
  assign m_axis_tuser  = out_clamp_q;

  // ---------------------------------------------------------------- checks
  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid filled while output was free");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a beat ahead of an empty output register");

  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_it.vld && dv_it.mode == MODE_SAMPLE) |->
      (NCTL_W'(seg) < n_eff && NCTL_W'(rd_idx[0]) < n_eff && NCTL_W'(rd_idx[3]) < n_eff))
    else $error("segment or neighbor index beyond control count");

endmodule
`default_nettype wire
